### rtl/ffr_pkg.sv
// Shared types and constants for the frame ring with random drop.
package ffr_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int MAX_FRAME_DEF = 1518;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int PERMILLE_W = 10;
  localparam int CNT_W      = 32;

  localparam logic [CNT_W-1:0]      LCG_MUL      = 32'd1103515245;
  localparam logic [CNT_W-1:0]      LCG_INC      = 32'd12345;
  localparam logic [CNT_W-1:0]      LCG_SEED     = 32'h12345678;
  localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_INJECTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_READ     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic rd_en;
    logic byte_we;
    logic len_we;
  } store_ctl_t;

endpackage

### rtl/ffr_req_if.sv
// Request channel: write bytes and read polls.
interface ffr_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ffr_pkg::BYTE_W-1:0] data_byte;
  logic [ffr_pkg::LEN_W-1:0]  frame_len;
  logic                       frame_last;

  modport source (output valid, func, data_byte, frame_len, frame_last, input ready);
  modport sink   (input valid, func, data_byte, frame_len, frame_last, output ready);
endinterface

### rtl/ffr_rsp_if.sv
// Result channel: status, read data and counters.
interface ffr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [ffr_pkg::BYTE_W-1:0] read_byte;
  logic [ffr_pkg::LEN_W-1:0]  read_len;
  logic                       read_last;
  logic [ffr_pkg::CNT_W-1:0]  sent_frames;
  logic [ffr_pkg::CNT_W-1:0]  sent_bytes;
  logic [ffr_pkg::CNT_W-1:0]  injected_count;
  logic [ffr_pkg::CNT_W-1:0]  full_count;

  modport source (output valid, status, read_byte, read_len, read_last, sent_frames,
                  sent_bytes, injected_count, full_count, input ready);
  modport sink   (input valid, status, read_byte, read_len, read_last, sent_frames,
                  sent_bytes, injected_count, full_count, output ready);
endinterface

### rtl/frame_fifo_with_random_drop.sv
// Top level: frame ring control, counters, result register.
// A new request is taken only once the last one has executed; execution waits
// while the result register holds an undrained result. Store reads and the
// registered LCG product are ready in the cycle after accept.
// Reset clears slots, offsets, counters, LCG and register; the stores are not
// cleared and need no clearing pass.
module frame_fifo_with_random_drop #(
  parameter int SLOTS     = ffr_pkg::SLOTS_DEF,
  parameter int MAX_FRAME = ffr_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ffr_pkg::PERMILLE_W-1:0] cfg_wdata,
  ffr_req_if.sink                        req,
  ffr_rsp_if.source                      rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = ffr_pkg::LEN_W;
  localparam int CW = ffr_pkg::CNT_W;

  ffr_pkg::ctl_state_t state, state_next;

  logic                       item_func;
  logic [ffr_pkg::BYTE_W-1:0] item_byte;
  logic [LW-1:0]              item_len;
  logic                       item_last;

  logic [SW-1:0] write_slot, write_slot_next;
  logic [SW-1:0] read_slot, read_slot_next;
  logic [LW-1:0] write_offset, write_offset_next;
  logic [LW-1:0] read_offset, read_offset_next;
  logic [LW-1:0] declared_len, declared_len_next;
  ffr_pkg::status_t frame_fate, frame_fate_next;
  logic mid_frame, mid_frame_next;
  logic [CW-1:0] sent_frames, sent_frames_next;
  logic [CW-1:0] sent_bytes, sent_bytes_next;
  logic [CW-1:0] injected_cnt, injected_cnt_next;
  logic [CW-1:0] full_cnt, full_cnt_next;
  logic [ffr_pkg::PERMILLE_W-1:0] drop_rate;

  logic                       out_valid;
  ffr_pkg::status_t           out_status;
  logic [ffr_pkg::BYTE_W-1:0] out_byte;
  logic [LW-1:0]              out_len;
  logic                       out_last;
  logic [CW-1:0]              out_frames, out_bytes, out_injected, out_full;

  logic                       res_valid;
  ffr_pkg::status_t           res_status;
  logic [ffr_pkg::BYTE_W-1:0] res_byte;
  logic [LW-1:0]              res_len;
  logic                       res_last;

  ffr_pkg::store_ctl_t        store_ctl;
  logic [LW-1:0]              byte_woff;
  logic [LW-1:0]              len_wdata;
  logic [ffr_pkg::BYTE_W-1:0] rd_byte;
  logic [LW-1:0]              rd_len;

  logic          lcg_step, lcg_hit;
  logic          exec_go;
  logic [SW-1:0] ws_inc, rs_inc;
  logic [LW-1:0] ro_inc, decl, wo, wo_new;
  logic          rd_end, first;
  ffr_pkg::status_t fate;

  ffr_store #(.SLOTS(SLOTS)) u_store (
    .clk       (clk),
    .ctl       (store_ctl),
    .rd_slot   (read_slot),
    .rd_offset (read_offset),
    .wr_slot   (write_slot),
    .wr_offset (byte_woff),
    .wr_byte   (item_byte),
    .wr_len    (len_wdata),
    .rd_byte   (rd_byte),
    .rd_len    (rd_len)
  );

  ffr_lcg u_lcg (
    .clk      (clk),
    .rst      (rst),
    .step     (lcg_step),
    .permille (drop_rate),
    .hit      (lcg_hit)
  );

  assign req.ready = (state == ffr_pkg::CS_IDLE);
  assign exec_go   = (state == ffr_pkg::CS_EXEC) && (!out_valid || rsp.ready);
  assign ws_inc    = (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + 1'b1;
  assign rs_inc    = (read_slot == SW'(SLOTS - 1)) ? '0 : read_slot + 1'b1;

  always_comb begin
    state_next        = state;
    write_slot_next   = write_slot;
    read_slot_next    = read_slot;
    write_offset_next = write_offset;
    read_offset_next  = read_offset;
    declared_len_next = declared_len;
    frame_fate_next   = frame_fate;
    mid_frame_next    = mid_frame;
    sent_frames_next  = sent_frames;
    sent_bytes_next   = sent_bytes;
    injected_cnt_next = injected_cnt;
    full_cnt_next     = full_cnt;
    store_ctl         = '0;
    byte_woff         = '0;
    len_wdata         = '0;
    lcg_step          = 1'b0;
    res_valid         = 1'b0;
    res_status        = ffr_pkg::ST_EMPTY;
    res_byte          = '0;
    res_len           = '0;
    res_last          = 1'b0;
    ro_inc            = read_offset + 1'b1;
    rd_end            = 1'b0;
    first             = !mid_frame;
    decl              = first ? item_len : declared_len;
    wo                = first ? '0 : write_offset;
    wo_new            = wo;
    fate              = frame_fate;
    case (state)
      ffr_pkg::CS_IDLE: begin
        if (req.valid) begin
          state_next      = ffr_pkg::CS_EXEC;
          store_ctl.rd_en = 1'b1;
        end
      end
      ffr_pkg::CS_EXEC: begin
        if (exec_go) begin
          state_next = ffr_pkg::CS_IDLE;
          if (item_func) begin
            res_valid = 1'b1;
            if (read_slot != write_slot) begin
              res_status = ffr_pkg::ST_READ;
              res_len    = rd_len;
              if (rd_len == '0) begin
                rd_end = 1'b1;
              end else begin
                res_byte         = rd_byte;
                rd_end           = (ro_inc >= rd_len);
                read_offset_next = ro_inc;
              end
              res_last = rd_end;
              if (rd_end) begin
                read_offset_next = '0;
                read_slot_next   = rs_inc;
              end
            end
          end else begin
            if (first) begin
              if (item_len > LW'(MAX_FRAME)) begin
                fate = ffr_pkg::ST_TOO_LONG;
              end else begin
                lcg_step = (drop_rate != '0);
                if ((drop_rate != '0) && lcg_hit) begin
                  fate = ffr_pkg::ST_INJECTED;
                end else if (ws_inc == read_slot) begin
                  fate = ffr_pkg::ST_FULL;
                end else begin
                  fate = ffr_pkg::ST_QUEUED;
                end
              end
            end
            if ((fate == ffr_pkg::ST_QUEUED) && (wo < decl)) begin
              store_ctl.byte_we = 1'b1;
              byte_woff         = wo;
              wo_new            = wo + 1'b1;
            end
            frame_fate_next   = fate;
            declared_len_next = decl;
            if (!item_last) begin
              mid_frame_next    = 1'b1;
              write_offset_next = wo_new;
            end else begin
              mid_frame_next    = 1'b0;
              write_offset_next = '0;
              res_valid         = 1'b1;
              res_status        = fate;
              case (fate)
                ffr_pkg::ST_QUEUED: begin
                  sent_frames_next = sent_frames + 1'b1;
                  sent_bytes_next  = sent_bytes + CW'(decl);
                  store_ctl.len_we = 1'b1;
                  len_wdata        = wo_new;
                  write_slot_next  = ws_inc;
                end
                ffr_pkg::ST_INJECTED: begin
                  sent_frames_next  = sent_frames + 1'b1;
                  sent_bytes_next   = sent_bytes + CW'(decl);
                  injected_cnt_next = injected_cnt + 1'b1;
                end
                ffr_pkg::ST_FULL: begin
                  full_cnt_next = full_cnt + 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      default: begin
        state_next = ffr_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ffr_pkg::CS_IDLE;
      write_slot    <= '0;
      read_slot     <= '0;
      write_offset  <= '0;
      read_offset   <= '0;
      declared_len  <= '0;
      frame_fate    <= ffr_pkg::ST_QUEUED;
      mid_frame     <= 1'b0;
      sent_frames   <= '0;
      sent_bytes    <= '0;
      injected_cnt  <= '0;
      full_cnt      <= '0;
      drop_rate     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
      write_offset  <= write_offset_next;
      read_offset   <= read_offset_next;
      declared_len  <= declared_len_next;
      frame_fate    <= frame_fate_next;
      mid_frame     <= mid_frame_next;
      sent_frames   <= sent_frames_next;
      sent_bytes    <= sent_bytes_next;
      injected_cnt  <= injected_cnt_next;
      full_cnt      <= full_cnt_next;
      if (cfg_wen) begin
        drop_rate <= (cfg_wdata > ffr_pkg::PERMILLE_MAX) ? ffr_pkg::PERMILLE_MAX
                                                         : cfg_wdata;
      end
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request beat and result payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_func <= req.func;
      item_byte <= req.data_byte;
      item_len  <= req.frame_len;
      item_last <= req.frame_last;
    end
    if (res_valid) begin
      out_status   <= res_status;
      out_byte     <= res_byte;
      out_len      <= res_len;
      out_last     <= res_last;
      out_frames   <= sent_frames_next;
      out_bytes    <= sent_bytes_next;
      out_injected <= injected_cnt_next;
      out_full     <= full_cnt_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_byte      = out_byte;
  assign rsp.read_len       = out_len;
  assign rsp.read_last      = out_last;
  assign rsp.sent_frames    = out_frames;
  assign rsp.sent_bytes     = out_bytes;
  assign rsp.injected_count = out_injected;
  assign rsp.full_count     = out_full;

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ffr_pkg::CS_EXEC)
    else $error("accepted beat did not start execution");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (32'(write_slot) < SLOTS) && (32'(read_slot) < SLOTS))
    else $error("slot pointer out of range");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_offset) <= MAX_FRAME)
    else $error("write offset beyond max frame");

  a_idle_offset: assert property (@(posedge clk) disable iff (rst)
    !mid_frame |-> write_offset == '0)
    else $error("write offset nonzero between frames");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ffr_pkg::ST_EMPTY) |->
      (out_byte == '0) && (out_len == '0) && !out_last)
    else $error("empty read carries data");
`endif

endmodule

### rtl/ffr_store.sv
// Frame byte memory and slot length memory, both with registered synchronous reads.
module ffr_store #(
  parameter int SLOTS = ffr_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  ffr_pkg::store_ctl_t         ctl,
  input  logic [$clog2(SLOTS)-1:0]    rd_slot,
  input  logic [ffr_pkg::LEN_W-1:0]   rd_offset,
  input  logic [$clog2(SLOTS)-1:0]    wr_slot,
  input  logic [ffr_pkg::LEN_W-1:0]   wr_offset,
  input  logic [ffr_pkg::BYTE_W-1:0]  wr_byte,
  input  logic [ffr_pkg::LEN_W-1:0]   wr_len,
  output logic [ffr_pkg::BYTE_W-1:0]  rd_byte,
  output logic [ffr_pkg::LEN_W-1:0]   rd_len
);

  localparam int BYTE_DEPTH = SLOTS * (2 ** ffr_pkg::LEN_W);

  logic [ffr_pkg::BYTE_W-1:0] byte_mem [BYTE_DEPTH];
  logic [ffr_pkg::LEN_W-1:0]  len_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.byte_we) begin
      byte_mem[{wr_slot, wr_offset}] <= wr_byte;
    end
    if (ctl.rd_en) begin
      rd_byte <= byte_mem[{rd_slot, rd_offset}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[wr_slot] <= wr_len;
    end
    if (ctl.rd_en) begin
      rd_len <= len_mem[rd_slot];
    end
  end

endmodule

### rtl/ffr_lcg.sv
// ANSI LCG with registered product and permille drop decision.
module ffr_lcg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [ffr_pkg::PERMILLE_W-1:0] permille,
  output logic                           hit
);

  logic [ffr_pkg::CNT_W-1:0] lcg_value;
  logic [ffr_pkg::CNT_W-1:0] lcg_prod;
  logic [14:0]               draw;
  logic [ffr_pkg::LEN_W-1:0] rem_raw;
  logic [ffr_pkg::LEN_W-1:0] rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_value <= ffr_pkg::LCG_SEED;
    end else if (step) begin
      lcg_value <= lcg_prod;
    end
  end

  always_ff @(posedge clk) begin
    lcg_prod <= lcg_value * ffr_pkg::LCG_MUL + ffr_pkg::LCG_INC;
  end

  // draw = 1024*k + m, so draw - 1000*k = m + 24*k stays below 2000
  assign draw    = lcg_prod[30:16];
  assign rem_raw = {1'b0, draw[9:0]} + (ffr_pkg::LEN_W'(draw[14:10]) * 11'd24);
  assign rem     = (rem_raw >= 11'd1000) ? rem_raw - 11'd1000 : rem_raw;
  assign hit     = rem < ffr_pkg::LEN_W'(permille);

endmodule

### test/tb.sv
// Testbench for frame_fifo_with_random_drop: queued stimulus, ring predictor, result checks.
module tb;

  localparam int SLOTS       = ffr_pkg::SLOTS_DEF;
  localparam int MAX_FRAME   = ffr_pkg::MAX_FRAME_DEF;
  localparam int BYTE_W      = ffr_pkg::BYTE_W;
  localparam int LEN_W       = ffr_pkg::LEN_W;
  localparam int PERMILLE_W  = ffr_pkg::PERMILLE_W;
  localparam int CNT_W       = ffr_pkg::CNT_W;
  localparam logic [CNT_W-1:0]      LCG_MUL      = ffr_pkg::LCG_MUL;
  localparam logic [CNT_W-1:0]      LCG_INC      = ffr_pkg::LCG_INC;
  localparam logic [CNT_W-1:0]      LCG_SEED     = ffr_pkg::LCG_SEED;
  localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = ffr_pkg::PERMILLE_MAX;
  localparam int SPAN        = 2048;
  localparam int LEN_MAX     = 2047;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;
  localparam bit FUNC_WRITE  = 1'b0;
  localparam bit FUNC_READ   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_len;
    logic              frame_last;
  } req_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  read_len;
    logic              read_last;
    logic [CNT_W-1:0]  sent_frames;
    logic [CNT_W-1:0]  sent_bytes;
    logic [CNT_W-1:0]  injected_count;
    logic [CNT_W-1:0]  full_count;
  } rsp_beat_t;

  typedef struct {
    int unsigned stamp;
    rsp_beat_t   beat;
  } due_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [PERMILLE_W-1:0] cfg_wdata;

  ffr_req_if req_ch ();
  ffr_rsp_if rsp_ch ();

  frame_fifo_with_random_drop dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // predictor state
  logic [BYTE_W-1:0]     ring_bytes [SLOTS*SPAN];
  logic [LEN_W-1:0]      slot_len [SLOTS];
  int unsigned           wr_slot = 0;
  int unsigned           rd_slot = 0;
  logic [LEN_W-1:0]      wr_off = '0;
  logic [LEN_W-1:0]      rd_off = '0;
  ffr_pkg::status_t      fate = ffr_pkg::ST_QUEUED;
  bit                    in_frame = 1'b0;
  logic [CNT_W-1:0]      lcg = LCG_SEED;
  logic [CNT_W-1:0]      sent_frames_q = '0;
  logic [CNT_W-1:0]      sent_bytes_q = '0;
  logic [CNT_W-1:0]      injected_q = '0;
  logic [CNT_W-1:0]      full_q = '0;
  logic [PERMILLE_W-1:0] permille_q = '0;

  req_beat_t   pending_beats [$];
  due_t        due_results [$];
  int unsigned cycle_count = 0;
  int          beats_accepted = 0;
  int          beats_queued = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          status_seen [8];

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int stall_mode = 0;

  function automatic bit frame_ring_predict(input req_beat_t b, output rsp_beat_t r);
    int unsigned      ws;
    int unsigned      rs;
    int unsigned      draw;
    logic [LEN_W-1:0] len;
    bit               done;
    bit               has;
    ws = wr_slot;
    rs = rd_slot;
    r = '0;
    has = 1'b1;
    if (b.func == FUNC_READ) begin
      if (rs == ws) begin
        r.status = ffr_pkg::ST_EMPTY;
      end else begin
        len = slot_len[rs];
        if (len == 0) begin
          done = 1'b1;
        end else begin
          r.read_byte = ring_bytes[rs*SPAN + rd_off];
          rd_off = rd_off + 1'b1;
          done = (rd_off >= len);
        end
        if (done) begin
          rd_off = '0;
          rd_slot = (rs + 1) % SLOTS;
        end
        r.status = ffr_pkg::ST_READ;
        r.read_len = len;
        r.read_last = done;
      end
    end else begin
      if (!in_frame) begin
        wr_off = '0;
        slot_len[ws] = b.frame_len;
        if (b.frame_len > MAX_FRAME) begin
          fate = ffr_pkg::ST_TOO_LONG;
        end else begin
          draw = 0;
          if (permille_q != 0) begin
            lcg = lcg * LCG_MUL + LCG_INC;
            draw = (lcg >> 16) & 32'h7FFF;
          end
          if (permille_q != 0 && (draw % PERMILLE_MAX) < permille_q) fate = ffr_pkg::ST_INJECTED;
          else if ((ws + 1) % SLOTS == rs) fate = ffr_pkg::ST_FULL;
          else fate = ffr_pkg::ST_QUEUED;
        end
      end
      if (fate == ffr_pkg::ST_QUEUED && wr_off < slot_len[ws]) begin
        ring_bytes[ws*SPAN + wr_off] = b.data_byte;
        wr_off = wr_off + 1'b1;
      end
      if (!b.frame_last) begin
        in_frame = 1'b1;
        has = 1'b0;
      end else begin
        in_frame = 1'b0;
        case (fate)
          ffr_pkg::ST_QUEUED: begin
            sent_frames_q = sent_frames_q + 1;
            sent_bytes_q = sent_bytes_q + CNT_W'(slot_len[ws]);
            slot_len[ws] = wr_off;
            wr_slot = (ws + 1) % SLOTS;
          end
          ffr_pkg::ST_INJECTED: begin
            injected_q = injected_q + 1;
            sent_frames_q = sent_frames_q + 1;
            sent_bytes_q = sent_bytes_q + CNT_W'(slot_len[ws]);
          end
          ffr_pkg::ST_FULL: begin
            full_q = full_q + 1;
          end
          default: ;
        endcase
        wr_off = '0;
        r.status = fate;
      end
    end
    r.sent_frames = sent_frames_q;
    r.sent_bytes = sent_bytes_q;
    r.injected_count = injected_q;
    r.full_count = full_q;
    return has;
  endfunction

  task automatic push_beat(input bit func, input int data, input int len, input bit last);
    req_beat_t b;
    b.func = func;
    b.data_byte = data[BYTE_W-1:0];
    b.frame_len = len[LEN_W-1:0];
    b.frame_last = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic push_reads(input int count);
    repeat (count) push_beat(FUNC_READ, $urandom_range(0, 255), $urandom_range(0, LEN_MAX), 1'($urandom_range(0, 1)));
  endtask

  // one frame of random shape, reads sometimes mixed in between its beats
  task automatic gen_frame();
    int kind;
    int d;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      d = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      n = (d == 0) ? 1 : d;
    end else if (kind < 70) begin
      d = ($urandom_range(0, 7) == 0) ? MAX_FRAME : $urandom_range(2, MAX_FRAME);
      n = $urandom_range(1, (d - 1 < 8) ? d - 1 : 8);
    end else if (kind < 85) begin
      d = $urandom_range(0, 4);
      n = d + $urandom_range(1, 3);
    end else begin
      case ($urandom_range(0, 5))
        0: d = LEN_MAX;
        1: d = MAX_FRAME + 1;
        default: d = $urandom_range(MAX_FRAME + 1, LEN_MAX);
      endcase
      n = $urandom_range(1, 3);
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) push_reads($urandom_range(1, 2));
      push_beat(FUNC_WRITE, $urandom_range(0, 255),
                (i == 0) ? d : $urandom_range(0, LEN_MAX), i == n - 1);
    end
  endtask

  task automatic random_mix(input int count);
    int stop_at;
    int pick;
    stop_at = beats_queued + count;
    while (beats_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) gen_frame();
      else if (pick < 85) push_reads($urandom_range(1, 6));
      else push_beat(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     $urandom_range(0, LEN_MAX), 1'($urandom_range(0, 1)));
    end
    push_beat(FUNC_WRITE, $urandom_range(0, 255), $urandom_range(0, 8), 1'b1);
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || req_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_permille(input int v);
    @(posedge clk);
    cfg_wdata <= v[PERMILLE_W-1:0];
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    permille_q = (v > PERMILLE_MAX) ? PERMILLE_MAX : v[PERMILLE_W-1:0];
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : cycle_guard
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : req_driver
    req_beat_t b;
    rsp_beat_t r;
    due_t      d;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        b.func = req_ch.func;
        b.data_byte = req_ch.data_byte;
        b.frame_len = req_ch.frame_len;
        b.frame_last = req_ch.frame_last;
        if (frame_ring_predict(b, r)) begin
          d.stamp = cycle_count;
          d.beat = r;
          due_results.push_back(d);
        end
        void'(pending_beats.pop_front());
        beats_accepted <= beats_accepted + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered beat
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        req_ch.valid <= 1'b1;
        req_ch.func <= pending_beats[0].func;
        req_ch.data_byte <= pending_beats[0].data_byte;
        req_ch.frame_len <= pending_beats[0].frame_len;
        req_ch.frame_last <= pending_beats[0].frame_last;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rsp_stall
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && beats_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 80);
        stall_mode = $urandom_range(0, 3);
      end else begin
        seg_left--;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= (cycle_count % 5) != 0;
      endcase
    end
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_beat_t got;
    due_t      d;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.read_byte = rsp_ch.read_byte;
      got.read_len = rsp_ch.read_len;
      got.read_last = rsp_ch.read_last;
      got.sent_frames = rsp_ch.sent_frames;
      got.sent_bytes = rsp_ch.sent_bytes;
      got.injected_count = rsp_ch.injected_count;
      got.full_count = rsp_ch.full_count;
      results_seen++;
      status_seen[got.status]++;
      if (due_results.size() == 0 || due_results[0].stamp == cycle_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: unexpected result beat status %0d byte %0h len %0d last %0d",
                   cycle_count, got.status, got.read_byte, got.read_len, got.read_last);
      end else begin
        d = due_results.pop_front();
        if (d.beat !== got) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: exp st %0d byte %0h len %0d last %0d cnt %0d/%0d/%0d/%0d",
                     cycle_count, d.beat.status, d.beat.read_byte, d.beat.read_len,
                     d.beat.read_last, d.beat.sent_frames, d.beat.sent_bytes,
                     d.beat.injected_count, d.beat.full_count);
            $display("cycle %0d: got st %0d byte %0h len %0d last %0d cnt %0d/%0d/%0d/%0d",
                     cycle_count, got.status, got.read_byte, got.read_len, got.read_last,
                     got.sent_frames, got.sent_bytes, got.injected_count, got.full_count);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int p_mid;
    int p_any;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_WRITE;
    req_ch.data_byte = '0;
    req_ch.frame_len = '0;
    req_ch.frame_last = 1'b0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty ring, empty frame, extremes, too long, early last, surplus
    write_permille(0);
    push_beat(FUNC_READ, 8'hFF, LEN_MAX, 1'b1);
    push_beat(FUNC_WRITE, 8'hFF, 0, 1'b1);
    push_beat(FUNC_READ, 8'h00, 0, 1'b0);
    push_beat(FUNC_WRITE, 8'h00, 3, 1'b0);
    push_beat(FUNC_READ, 8'h00, 0, 1'b0);
    push_beat(FUNC_WRITE, 8'hFF, LEN_MAX, 1'b0);
    push_beat(FUNC_WRITE, 8'hA5, 0, 1'b1);
    push_beat(FUNC_WRITE, 8'h11, LEN_MAX, 1'b1);
    push_beat(FUNC_WRITE, 8'h22, MAX_FRAME + 1, 1'b0);
    push_beat(FUNC_WRITE, 8'h33, 0, 1'b1);
    push_beat(FUNC_WRITE, 8'h81, MAX_FRAME, 1'b0);
    push_beat(FUNC_WRITE, 8'h7E, 5, 1'b1);
    push_beat(FUNC_WRITE, 8'h5A, 1, 1'b0);
    push_beat(FUNC_WRITE, 8'h3C, 9, 1'b0);
    push_beat(FUNC_WRITE, 8'hC3, 9, 1'b1);
    push_reads(7);
    settle();

    write_permille(1023);
    push_beat(FUNC_WRITE, 8'h01, 0, 1'b1);
    push_beat(FUNC_WRITE, 8'h02, 2, 1'b0);
    push_beat(FUNC_WRITE, 8'h03, 2, 1'b1);
    push_reads(2);
    settle();

    // fill the ring past full and drain it, twice
    write_permille(0);
    repeat (2) begin
      repeat (68) begin
        int d;
        d = $urandom_range(0, 2);
        for (int i = 0; i < ((d == 0) ? 1 : d); i++)
          push_beat(FUNC_WRITE, $urandom_range(0, 255), d, i == ((d == 0) ? 0 : d - 1));
      end
      push_reads(140);
    end
    settle();

    p_mid = $urandom_range(1, 999);
    write_permille(p_mid);
    random_mix(400);
    settle();

    write_permille(PERMILLE_MAX);
    random_mix(150);
    settle();

    p_any = $urandom_range(0, 1023);
    write_permille(p_any);
    random_mix(300);
    settle();
    repeat (12) @(posedge clk);

    if (due_results.size() != 0) mismatches += due_results.size();
    $display("Covered %0d request beats, %0d result beats, drop settings 0, 1023, %0d, 1000, %0d.",
             beats_accepted, results_seen, p_mid, p_any);
    $display("Statuses: %0d queued, %0d injected, %0d full, %0d too long, %0d reads, %0d empty.",
             status_seen[ffr_pkg::ST_QUEUED], status_seen[ffr_pkg::ST_INJECTED],
             status_seen[ffr_pkg::ST_FULL], status_seen[ffr_pkg::ST_TOO_LONG],
             status_seen[ffr_pkg::ST_READ], status_seen[ffr_pkg::ST_EMPTY]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
